>>> design/traffic_light_controller_with_setup_defines.svh
// assertion macros used by the checker file
`ifndef TRAFFIC_LIGHT_CONTROLLER_WITH_SETUP_DEFINES_SVH
`define TRAFFIC_LIGHT_CONTROLLER_WITH_SETUP_DEFINES_SVH

// same-cycle implication under active-low reset
`define TLC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication under active-low reset
`define TLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/tlc_pkg.sv
// shared types, constants and helper functions of the traffic light controller
`default_nettype none

package tlc_pkg;

  // largest value the edit counter may reach before wrapping to one
  localparam int unsigned MAX_SETTING = 99;

  // lamp bits of one road
  localparam logic [2:0] LAMP_OFF   = 3'b000;
  localparam logic [2:0] LAMP_RED   = 3'b100;
  localparam logic [2:0] LAMP_AMBER = 3'b010;
  localparam logic [2:0] LAMP_GREEN = 3'b001;

  // phase codes of the normal cycle
  localparam logic [1:0] PHASE_R1RED_R2GREEN = 2'd0;
  localparam logic [1:0] PHASE_R1RED_R2AMBER = 2'd1;
  localparam logic [1:0] PHASE_R1GREEN_R2RED = 2'd2;
  localparam logic [1:0] PHASE_R1AMBER_R2RED = 2'd3;

  // reset values of the durations and timer
  localparam logic [6:0] RED_RESET    = 7'd5;
  localparam logic [6:0] AMBER_RESET  = 7'd2;
  localparam logic [6:0] GREEN_RESET  = 7'd3;
  localparam logic [6:0] TIMER_RESET  = 7'd3;
  localparam logic [6:0] EDIT_RESET   = 7'd1;

  // operating mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_RED    = 4'b0010,
    MODE_AMBER  = 4'b0100,
    MODE_GREEN  = 4'b1000
  } mode_e;

  // one input word, last field in the lowest bit
  typedef struct packed {
    logic set_press;
    logic inc_hold;
    logic inc_press;
    logic mode_press;
    logic blink_tick;
    logic second_tick;
  } item_t;

  // one result word, last field in the lowest bits
  typedef struct packed {
    logic       show_dashes;
    logic [7:0] right_number;
    logic [7:0] left_number;
    logic [2:0] road2_lamps;
    logic [2:0] road1_lamps;
    logic [1:0] mode_now;
  } result_t;

  // mode number as shown on the output
  function automatic logic [1:0] mode_num(mode_e m);
    logic [1:0] n;
    case (m)
      MODE_NORMAL: n = 2'd0;
      MODE_RED:    n = 2'd1;
      MODE_AMBER:  n = 2'd2;
      MODE_GREEN:  n = 2'd3;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

  // lamps of both roads for a phase: road one in bits 5..3
  function automatic logic [5:0] phase_lamps(logic [1:0] ph);
    logic [5:0] l;
    case (ph)
      PHASE_R1RED_R2GREEN: l = {LAMP_RED, LAMP_GREEN};
      PHASE_R1RED_R2AMBER: l = {LAMP_RED, LAMP_AMBER};
      PHASE_R1GREEN_R2RED: l = {LAMP_GREEN, LAMP_RED};
      PHASE_R1AMBER_R2RED: l = {LAMP_AMBER, LAMP_RED};
      default:             l = {LAMP_OFF, LAMP_OFF};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

>>> design/tlc_in_stage.sv
// input register of the controller
`default_nettype none

module tlc_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire tlc_pkg::item_t in_item_i,
  input  wire logic          take_i,
  output      logic          valid_o,
  output      tlc_pkg::item_t item_o
);
  import tlc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // room when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> design/tlc_core.sv
// controller state and its update for one word
`default_nettype none

module tlc_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire tlc_pkg::item_t   item_i,
  output      tlc_pkg::result_t result_o
);
  import tlc_pkg::*;

  mode_e      mode_q, mode_d;
  logic [1:0] phase_q, phase_d;
  logic [6:0] timer_q, timer_d;
  logic [6:0] red_q, red_d;
  logic [6:0] amber_q, amber_d;
  logic [6:0] green_q, green_d;
  logic [6:0] edit_q, edit_d;
  logic       blink_q, blink_d;
  logic [5:0] lamps_q, lamps_d;

  logic [7:0] sum_q_times;
  logic       cons_now;
  logic [7:0] sum_d_times;
  logic       cons_next;
  logic [2:0] colour;
  logic [7:0] inc_val;
  logic [7:0] timer_ext;
  logic [7:0] amber_ext;

  // durations consistent before the update
  assign sum_q_times = {1'b0, green_q} + {1'b0, amber_q};
  assign cons_now    = ({1'b0, red_q} == sum_q_times);

  // blink colour of the current setup mode
  always_comb begin
    case (mode_q)
      MODE_RED:   colour = LAMP_RED;
      MODE_AMBER: colour = LAMP_AMBER;
      MODE_GREEN: colour = LAMP_GREEN;
      default:    colour = LAMP_AMBER;
    endcase
  end

  // edit value plus one; the wrap to one is applied where it is used
  assign inc_val = {1'b0, edit_q} + 8'd1;

  // next state
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    timer_d = timer_q;
    red_d   = red_q;
    amber_d = amber_q;
    green_d = green_q;
    edit_d  = edit_q;
    blink_d = blink_q;
    lamps_d = lamps_q;
    if (mode_q == MODE_NORMAL) begin
      if (!cons_now) begin
        if (item_i.blink_tick) begin
          blink_d = !blink_q;
          lamps_d = !blink_q ? {colour, colour} : 6'd0;
        end
      end else if (item_i.second_tick) begin
        // count down, advance and reload at zero
        if (timer_q != 7'd0) begin
          timer_d = timer_q - 7'd1;
        end
        if (timer_d == 7'd0) begin
          phase_d = phase_q + 2'd1;
          timer_d = phase_d[0] ? amber_q : green_q;
        end
        lamps_d = phase_lamps(phase_d);
      end
      if (item_i.mode_press) begin
        lamps_d = 6'd0;
        mode_d  = MODE_RED;
        edit_d  = red_q;
      end
    end else begin
      if (item_i.blink_tick) begin
        blink_d = !blink_q;
        lamps_d = !blink_q ? {colour, colour} : 6'd0;
      end
      // one button per word in priority order
      if (item_i.mode_press) begin
        lamps_d = 6'd0;
        case (mode_q)
          MODE_RED: begin
            mode_d = MODE_AMBER;
            edit_d = amber_q;
          end
          MODE_AMBER: begin
            mode_d = MODE_GREEN;
            edit_d = green_q;
          end
          default: begin
            mode_d  = MODE_NORMAL;
            phase_d = PHASE_R1RED_R2GREEN;
            timer_d = green_q;
          end
        endcase
      end else if (item_i.inc_press || item_i.inc_hold) begin
        edit_d = (inc_val > 8'(MAX_SETTING)) ? 7'd1 : inc_val[6:0];
      end else if (item_i.set_press) begin
        case (mode_q)
          MODE_RED:   red_d   = edit_q;
          MODE_AMBER: amber_d = edit_q;
          default:    green_d = edit_q;
        endcase
      end
    end
  end

  // durations consistent after the update
  assign sum_d_times = {1'b0, green_d} + {1'b0, amber_d};
  assign cons_next   = ({1'b0, red_d} == sum_d_times);
  assign timer_ext   = {1'b0, timer_d};
  assign amber_ext   = {1'b0, amber_d};

  // result from the updated state
  always_comb begin
    result_o.mode_now     = mode_num(mode_d);
    result_o.road1_lamps  = lamps_d[5:3];
    result_o.road2_lamps  = lamps_d[2:0];
    result_o.left_number  = 8'd0;
    result_o.right_number = 8'd0;
    result_o.show_dashes  = 1'b0;
    if (mode_d == MODE_NORMAL) begin
      if (!cons_next) begin
        result_o.show_dashes = 1'b1;
      end else begin
        result_o.left_number  = timer_ext;
        result_o.right_number = timer_ext;
        if (phase_d == PHASE_R1RED_R2GREEN) begin
          result_o.left_number = timer_ext + amber_ext;
        end else if (phase_d == PHASE_R1GREEN_R2RED) begin
          result_o.right_number = timer_ext + amber_ext;
        end
      end
    end else begin
      result_o.left_number  = {6'd0, mode_num(mode_d)} + 8'd1;
      result_o.right_number = {1'b0, edit_d};
    end
  end

  // state registers, updated once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      phase_q <= PHASE_R1RED_R2GREEN;
      timer_q <= TIMER_RESET;
      red_q   <= RED_RESET;
      amber_q <= AMBER_RESET;
      green_q <= GREEN_RESET;
      edit_q  <= EDIT_RESET;
      blink_q <= 1'b0;
      lamps_q <= 6'd0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      timer_q <= timer_d;
      red_q   <= red_d;
      amber_q <= amber_d;
      green_q <= green_d;
      edit_q  <= edit_d;
      blink_q <= blink_d;
      lamps_q <= lamps_d;
    end
  end

endmodule

`default_nettype wire

>>> design/tlc_out_stage.sv
// result register of the controller
`default_nettype none

module tlc_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire tlc_pkg::result_t result_i,
  output      logic             free_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      tlc_pkg::result_t result_o
);
  import tlc_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // free when empty or when the held word is taken now
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

>>> design/traffic_light_controller_with_setup.sv
// top level of the two-road traffic light controller with setup modes
//
//   channel  | dir | fields (lowest bit first)
//   s_axis   | in  | second_tick, blink_tick, mode_press, inc_press, inc_hold, set_press
//   m_axis   | out | mode_now, road1_lamps, road2_lamps, left_number, right_number,
//            |     | show_dashes
//
// one word per clock sustained while the result side does not stall; a taken word passes
// through the input register, then the state update into the result register
// rst_ni clears the valid flags and controller state at once to normal mode, phase zero, timer 3, durations 5/2/3
// a stalled result holds the update; the input register keeps taking a word while the
// result register is being emptied in the same cycle
`default_nettype none

module traffic_light_controller_with_setup (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] second_tick [1] blink_tick [2] mode_press [3] inc_press [4] inc_hold
  // [5] set_press [7:6] zero
  input  wire logic [7:0]  s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] mode_now [4:2] road1_lamps [7:5] road2_lamps [15:8] left_number
  // [23:16] right_number [24] show_dashes [31:25] zero
  output      logic [31:0] m_axis_tdata
);
  import tlc_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_free;
  logic    advance;
  result_t core_result;
  result_t out_result;

  assign in_item = item_t'(s_axis_tdata[5:0]);

  // word moves into the result register when that register has room
  assign advance = stage_valid && out_free;

  // input register
  tlc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (out_free),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // state update
  tlc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (stage_item),
    .result_o (core_result)
  );

  // result register
  tlc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = {7'd0, out_result};

endmodule

`default_nettype wire

>>> design/tlc_checker.sv
// port-level checks of the traffic light controller and their bind
`default_nettype none

`include "traffic_light_controller_with_setup_defines.svh"

module tlc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // a stalled result word stays and holds
  `TLC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // dashes blank both numbers
  `TLC_ASSERT_NOW(a_dash_blank, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[24], m_axis_tdata[23:8] == 16'd0)

  // dashes only in normal mode
  `TLC_ASSERT_NOW(a_dash_normal, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[24], m_axis_tdata[1:0] == 2'd0)

  // setup modes show the mode number plus one on the left
  `TLC_ASSERT_NOW(a_setup_left, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[15:8] == ({6'd0, m_axis_tdata[1:0]} + 8'd1))

endmodule

bind traffic_light_controller_with_setup tlc_checker u_tlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// testbench of the traffic light controller: tick and button words checked against a predictor

module tb_top;
  import tlc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_WORDS = 650;
  localparam int DRAIN_CYCLES = 8;

  // mode number as it shows on the result word
  typedef enum logic [1:0] {
    SHOWN_NORMAL = 2'd0,
    SHOWN_RED    = 2'd1,
    SHOWN_AMBER  = 2'd2,
    SHOWN_GREEN  = 2'd3
  } mode_shown_e;

  // predicted controller state and the queue of displays still to come
  class display_scoreboard;
    mode_shown_e mode;
    logic [1:0]  phase;
    logic [6:0]  timer;
    logic [6:0]  red_t;
    logic [6:0]  amber_t;
    logic [6:0]  green_t;
    logic [6:0]  edit;
    logic        blink;
    logic [5:0]  latch;
    result_t     display_q[$];
    int          fails;

    function new();
      mode    = SHOWN_NORMAL;
      phase   = PHASE_R1RED_R2GREEN;
      timer   = TIMER_RESET;
      red_t   = RED_RESET;
      amber_t = AMBER_RESET;
      green_t = GREEN_RESET;
      edit    = EDIT_RESET;
      blink   = 1'b0;
      latch   = '0;
      fails   = 0;
    endfunction

    // sums taken at 8 bits so two large durations do not wrap
    function bit durations_match();
      return {1'b0, red_t} == {1'b0, green_t} + {1'b0, amber_t};
    endfunction

    function void toggle_blink(logic [2:0] colour);
      blink = ~blink;
      latch = blink ? {colour, colour} : 6'd0;
    endfunction

    // advance the predicted state by one word and queue the display it gives
    function void take_input(item_t it);
      result_t     r;
      logic [2:0]  colour;
      if (mode == SHOWN_NORMAL) begin
        if (!durations_match()) begin
          if (it.blink_tick) toggle_blink(LAMP_AMBER);
        end else if (it.second_tick) begin
          // count down, a spent timer steps the phase at once
          if (timer != 7'd0) timer = timer - 7'd1;
          if (timer == 7'd0) begin
            phase = phase + 2'd1;
            timer = phase[0] ? amber_t : green_t;
          end
          case (phase)
            PHASE_R1RED_R2GREEN: latch = {LAMP_RED, LAMP_GREEN};
            PHASE_R1RED_R2AMBER: latch = {LAMP_RED, LAMP_AMBER};
            PHASE_R1GREEN_R2RED: latch = {LAMP_GREEN, LAMP_RED};
            default:             latch = {LAMP_AMBER, LAMP_RED};
          endcase
        end
        if (it.mode_press) begin
          latch = '0;
          mode  = SHOWN_RED;
          edit  = red_t;
        end
      end else begin
        case (mode)
          SHOWN_RED:   colour = LAMP_RED;
          SHOWN_AMBER: colour = LAMP_AMBER;
          default:     colour = LAMP_GREEN;
        endcase
        if (it.blink_tick) toggle_blink(colour);
        // one button per word: mode, increment, set
        if (it.mode_press) begin
          latch = '0;
          case (mode)
            SHOWN_RED: begin
              mode = SHOWN_AMBER;
              edit = amber_t;
            end
            SHOWN_AMBER: begin
              mode = SHOWN_GREEN;
              edit = green_t;
            end
            default: begin
              mode  = SHOWN_NORMAL;
              phase = PHASE_R1RED_R2GREEN;
              timer = green_t;
            end
          endcase
        end else if (it.inc_press || it.inc_hold) begin
          edit = (int'(edit) >= MAX_SETTING) ? 7'd1 : edit + 7'd1;
        end else if (it.set_press) begin
          case (mode)
            SHOWN_RED:   red_t   = edit;
            SHOWN_AMBER: amber_t = edit;
            default:     green_t = edit;
          endcase
        end
      end

      // display after the update
      r             = '0;
      r.mode_now    = mode;
      r.road1_lamps = latch[5:3];
      r.road2_lamps = latch[2:0];
      if (mode == SHOWN_NORMAL) begin
        if (!durations_match()) begin
          r.show_dashes = 1'b1;
        end else begin
          r.left_number  = {1'b0, timer};
          r.right_number = {1'b0, timer};
          if (phase == PHASE_R1RED_R2GREEN)
            r.left_number = {1'b0, timer} + {1'b0, amber_t};
          else if (phase == PHASE_R1GREEN_R2RED)
            r.right_number = {1'b0, timer} + {1'b0, amber_t};
        end
      end else begin
        r.left_number  = {6'd0, mode} + 8'd1;
        r.right_number = {1'b0, edit};
      end
      display_q.push_back(r);
    endfunction

    // compare one taken result word with the oldest predicted display
    function void check_display(logic [31:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[24:0]);
      if (display_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word %h", word);
        return;
      end
      want = display_q.pop_front();
      if (got.mode_now !== want.mode_now || got.road1_lamps !== want.road1_lamps ||
          got.road2_lamps !== want.road2_lamps || got.left_number !== want.left_number ||
          got.right_number !== want.right_number || got.show_dashes !== want.show_dashes)
      begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch exp: mode %0d lamps %b %b numbers %0d %0d dashes %b",
                   want.mode_now, want.road1_lamps, want.road2_lamps,
                   want.left_number, want.right_number, want.show_dashes);
          $display("         got: mode %0d lamps %b %b numbers %0d %0d dashes %b",
                   got.mode_now, got.road1_lamps, got.road2_lamps,
                   got.left_number, got.right_number, got.show_dashes);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  display_scoreboard sb = new();
  int  words_sent = 0;
  int  cycle_count = 0;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;

  traffic_light_controller_with_setup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // idle length per word, with calm stretches that have no gaps at all
  function automatic int idle_cycles(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic item_t make_item(bit sec, bit blk, bit md, bit inc, bit hold, bit set);
    return {set, hold, inc, md, blk, sec};
  endfunction

  // increments needed to walk the edit value to a goal, through the wrap if needed
  function automatic int incs_to(logic [6:0] from, int goal);
    if (goal >= int'(from)) return goal - int'(from);
    return MAX_SETTING - int'(from) + goal;
  endfunction

  // offer one word and wait until it is taken
  task automatic send_item(item_t it);
    int gap;
    @(negedge clk_i);
    gap = idle_cycles(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_input(it);
    words_sent++;
  endtask

  // hold off the sender until every predicted display has come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.display_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_bits_item(bit md);
    send_item(make_item($urandom_range(0, 1), $urandom_range(0, 1), md,
                        $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
  endtask

  // walk through the three setup modes storing chosen durations
  task automatic setup_session();
    int goal[3];
    int a;
    int g;
    int n;
    int k;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(1, 50);
        g = $urandom_range(1, 49);
      end else begin
        a = $urandom_range(1, 4);
        g = $urandom_range(1, 6);
      end
      goal[0] = a + g;
      goal[1] = a;
      goal[2] = g;
    end else begin
      foreach (goal[i]) goal[i] = $urandom_range(1, MAX_SETTING);
    end
    while (sb.mode != SHOWN_RED) random_bits_item(1'b1);
    for (int c = 0; c < 3; c++) begin
      if ($urandom_range(0, 9) < 8) begin
        n = incs_to(sb.edit, goal[c]);
        repeat (n) begin
          k = $urandom_range(1, 3);
          send_item(make_item($urandom_range(0, 1), $urandom_range(0, 1), 1'b0,
                              k[0], k[1], $urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) < 9)
          send_item(make_item($urandom_range(0, 1), $urandom_range(0, 1), 1'b0, 1'b0, 1'b0, 1'b1));
      end
      random_bits_item(1'b1);
    end
  endtask

  // normal running, mostly second ticks
  task automatic normal_run();
    int len;
    while (sb.mode != SHOWN_NORMAL) random_bits_item(1'b1);
    len = $urandom_range(8, 40);
    repeat (len)
      send_item(make_item($urandom_range(0, 9) < 7, $urandom_range(0, 1), 1'b0,
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0));
  endtask

  // result side: random stalls, check on every taken word
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = idle_cycles(snk_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_display(m_axis_tdata);
    end
  end

  // reset, directed words, then random episodes
  initial begin
    int pick;
    int len;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle word, then a full phase cycle with ignored buttons
    send_item(make_item(0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 11; i++)
      send_item(make_item(1, i % 2, 0, i == 3, i == 5, i == 7));
    // tick together with mode: update first, then into red setup
    send_item(make_item(1, 0, 1, 0, 0, 0));
    send_item(make_item(0, 1, 0, 0, 0, 0));
    send_item(make_item(0, 1, 0, 1, 0, 0));
    // hold beats set
    send_item(make_item(0, 0, 0, 0, 1, 1));
    send_item(make_item(0, 0, 0, 0, 0, 1));
    // every button at once: mode wins
    send_item(make_item(1, 1, 1, 1, 1, 1));
    send_item(make_item(0, 0, 0, 1, 1, 0));
    send_item(make_item(0, 1, 0, 0, 0, 1));
    send_item(make_item(0, 0, 1, 0, 0, 0));
    // back to normal with mismatched durations: dashes and blinking amber
    send_item(make_item(0, 0, 1, 0, 0, 0));
    send_item(make_item(1, 1, 0, 1, 0, 1));
    send_item(make_item(1, 1, 0, 0, 1, 0));
    send_item(make_item(0, 1, 1, 0, 0, 0));
    settle();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        normal_run();
      end else if (pick < 85) begin
        setup_session();
      end else begin
        len = $urandom_range(3, 8);
        repeat (len) send_item(item_t'(6'($urandom_range(0, 63))));
      end
      if ($urandom_range(0, 99) < 15) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
